FILE: rtl/kbar_pkg.sv
// Package for the keyed byte aggregation ranker: codes, widths, row record type.
// No dependencies.
package kbar_pkg;
    localparam int KEY_W   = 64;
    localparam int SUM_W   = 64;
    localparam int CNT_W   = 32;
    localparam int BYTES_W = 48;
    localparam int ROWREC_W = 2*KEY_W + SUM_W + CNT_W;

    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    localparam logic [1:0] AXIS_TYPE   = 2'd0;
    localparam logic [1:0] AXIS_THREAD = 2'd1;
    localparam logic [1:0] AXIS_CELL   = 2'd2;
    localparam logic [1:0] AXIS_ASSET  = 2'd3;

    localparam logic [7:0] REG_AXIS  = 8'd0;
    localparam logic [7:0] REG_LIMIT = 8'd1;

    typedef struct packed {
        logic [KEY_W-1:0] key_lo;
        logic [KEY_W-1:0] key_hi;
        logic [SUM_W-1:0] bytes;
        logic [CNT_W-1:0] count;
    } row_rec_t;
endpackage

FILE: rtl/kbar_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module kbar_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

FILE: rtl/keyed_byte_aggregation_ranker_unit.sv
// Top level of the keyed byte aggregation ranker: control FSM around one row RAM.
// Depends on kbar_pkg and kbar_ram.
//
// channel | dir | handshake               | payload
// s_      | in  | s_tvalid/s_tready       | s_tdata record, s_tuser operation
// m_      | out | m_tvalid/m_tready       | m_tdata report fields, m_tuser is_summary, m_tlast
// cfg_    | in  | cfg_valid/cfg_ready     | cfg_index, cfg_data
//
// Add: a zero key retires in the accept cycle. Otherwise each stored row is compared in
//   turn (RAM read in ST_SCAN, then compare in ST_CMP) until a match; past the last row
//   the key is allocated or counted as overflow. The single RAM read port makes the scan serial.
// Finish: insertion sort over the RAM (ST_SORTA, ST_SORTB, ST_SORTC per row, ST_SORTC
//   repeating for each shift, n*(n-1)/2 shifts worst case), then n+1 results: each row
//   (ST_EMITR, then ST_EMITW), then the summary, each held by m_tready stalls.
// Reset clears counters and sums and sets config to type axis, limit 16; RAM contents
//   are never cleared, a row count marks what is live. An output register holds each result until taken.
module keyed_byte_aggregation_ranker_unit
    import kbar_pkg::*;
#(
    parameter int ROWS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [63:0] type_key, [95:64] thread_id, [159:96] cell_id,
    // [223:160] asset_low_half, [287:224] asset_high_half, [335:288] alloc_bytes
    input  logic [335:0] s_tdata,
    // [0] operation
    input  logic [0:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [63:0] key_lower, [127:64] key_upper, [191:128] row_bytes,
    // [223:192] row_allocations, [287:224] unattributed_total,
    // [351:288] unreported_total, [415:352] reported_total,
    // [447:416] distinct_count, [452:448] rows_reported, [455:453] zero
    output logic [455:0] m_tdata,
    // [0] is_summary
    output logic [0:0]   m_tuser,
    output logic         m_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [7:0]   cfg_index,
    input  logic [31:0]  cfg_data
);
    localparam int AW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int NW = $clog2(ROWS + 1);
    localparam int RD = 1 << AW;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_SCAN  = 9'b000000010,
        ST_CMP   = 9'b000000100,
        ST_SORTA = 9'b000001000,
        ST_SORTB = 9'b000010000,
        ST_SORTC = 9'b000100000,
        ST_EMITR = 9'b001000000,
        ST_EMITW = 9'b010000000,
        ST_SUMM  = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    logic [1:0] axis_reg;
    logic [4:0] limit_reg;
    logic [NW-1:0] used_reg, used_next;
    logic [SUM_W-1:0] unatt_reg, unatt_next, unrep_reg, unrep_next, rep_reg, rep_next;
    logic [CNT_W-1:0] dist_reg, dist_next;

    logic [KEY_W-1:0] klo_reg, klo_next, khi_reg, khi_next;
    logic [BYTES_W-1:0] bytes_reg, bytes_next;
    logic [NW-1:0] idx_reg, idx_next;   // scan index / sort outer i / emit index
    logic [NW-1:0] pos_reg, pos_next;   // sort inner p
    row_rec_t hold_reg, hold_next;      // element being inserted

    logic m_valid_reg, m_valid_next;
    logic [455:0] m_data_reg, m_data_next;
    logic m_sum_reg, m_sum_next;

    // RAM
    logic ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    row_rec_t ram_wdata, ram_rdata;
    logic [ROWREC_W-1:0] ram_rbits;

    kbar_ram #(.WIDTH(ROWREC_W), .DEPTH(RD)) u_rows (
        .aclk(aclk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
        .raddr(ram_raddr), .rdata(ram_rbits)
    );
    assign ram_rdata = row_rec_t'(ram_rbits);

    // capacity saturates at ROWS
    logic [NW:0] cap;
    assign cap = ({1'b0, limit_reg} > 6'(ROWS)) ? (NW+1)'(ROWS) : (NW+1)'(limit_reg);

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE) && !m_valid_reg;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign m_tuser   = m_sum_reg;
    assign m_tlast   = m_sum_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            axis_reg  <= AXIS_TYPE;
            limit_reg <= 5'd16;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == REG_AXIS)  axis_reg  <= cfg_data[1:0];
            if (cfg_index == REG_LIMIT) limit_reg <= cfg_data[4:0];
        end
    end

    logic [KEY_W-1:0] in_lo, in_hi;
    always_comb begin
        in_hi = '0;
        case (axis_reg)
            AXIS_TYPE:   in_lo = s_tdata[63:0];
            AXIS_THREAD: in_lo = {32'd0, s_tdata[95:64]};
            AXIS_CELL:   in_lo = s_tdata[159:96];
            default: begin
                in_lo = s_tdata[223:160];
                in_hi = s_tdata[287:224];
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        used_next = used_reg; unatt_next = unatt_reg; unrep_next = unrep_reg;
        rep_next = rep_reg; dist_next = dist_reg;
        klo_next = klo_reg; khi_next = khi_reg; bytes_next = bytes_reg;
        idx_next = idx_reg; pos_next = pos_reg; hold_next = hold_reg;
        m_valid_next = m_valid_reg; m_data_next = m_data_reg; m_sum_next = m_sum_reg;
        ram_we = 1'b0; ram_waddr = '0; ram_wdata = hold_reg; ram_raddr = '0;

        if (m_valid_reg && m_tready) m_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    idx_next = '0;
                    if (s_tuser[0] == OP_FINISH) begin
                        idx_next = NW'(1);
                        state_next = ST_SORTA;
                    end else begin
                        klo_next = in_lo; khi_next = in_hi;
                        bytes_next = s_tdata[335:288];
                        if (in_lo == '0 && in_hi == '0) begin
                            unatt_next = unatt_reg + SUM_W'(s_tdata[335:288]);
                        end else begin
                            state_next = ST_SCAN;
                        end
                    end
                end
            end
            ST_SCAN: begin
                // issue read of row idx, or resolve as new key
                if (idx_reg == used_reg) begin
                    dist_next = dist_reg + 1'b1;
                    state_next = ST_IDLE;
                    if ({1'b0, used_reg} >= cap) begin
                        unrep_next = unrep_reg + SUM_W'(bytes_reg);
                    end else begin
                        ram_we = 1'b1;
                        ram_waddr = idx_reg[AW-1:0];
                        ram_wdata = '{key_lo: klo_reg, key_hi: khi_reg,
                                      bytes: SUM_W'(bytes_reg), count: CNT_W'(1)};
                        used_next = used_reg + 1'b1;
                        rep_next = rep_reg + SUM_W'(bytes_reg);
                    end
                end else begin
                    ram_raddr = idx_reg[AW-1:0];
                    state_next = ST_CMP;
                end
            end
            ST_CMP: begin
                if (ram_rdata.key_lo == klo_reg && ram_rdata.key_hi == khi_reg) begin
                    ram_we = 1'b1;
                    ram_waddr = idx_reg[AW-1:0];
                    ram_wdata = ram_rdata;
                    ram_wdata.bytes = ram_rdata.bytes + SUM_W'(bytes_reg);
                    ram_wdata.count = ram_rdata.count + 1'b1;
                    rep_next = rep_reg + SUM_W'(bytes_reg);
                    state_next = ST_IDLE;
                end else begin
                    idx_next = idx_reg + 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SORTA: begin
                // start insertion of element i
                if (idx_reg >= used_reg) begin
                    idx_next = '0;
                    state_next = ST_EMITR;
                end else begin
                    ram_raddr = idx_reg[AW-1:0];
                    pos_next = idx_reg;
                    state_next = ST_SORTB;
                end
            end
            ST_SORTB: begin
                hold_next = ram_rdata;
                ram_raddr = AW'(idx_reg - 1'b1);
                state_next = ST_SORTC;
            end
            ST_SORTC: begin
                // ram_rdata holds row pos-1
                if (ram_rdata.bytes < hold_reg.bytes) begin
                    ram_we = 1'b1;
                    ram_waddr = pos_reg[AW-1:0];
                    ram_wdata = ram_rdata;
                    pos_next = pos_reg - 1'b1;
                    ram_raddr = AW'(pos_reg - NW'(2));
                end else begin
                    ram_we = 1'b1;
                    ram_waddr = pos_reg[AW-1:0];
                    ram_wdata = hold_reg;
                    idx_next = idx_reg + 1'b1;
                    state_next = ST_SORTA;
                end
                // reached the front: hold goes to row 0
                if (pos_reg == '0) begin
                    ram_we = 1'b1;
                    ram_waddr = '0;
                    ram_wdata = hold_reg;
                    pos_next = pos_reg;
                    idx_next = idx_reg + 1'b1;
                    state_next = ST_SORTA;
                end
            end
            ST_EMITR: begin
                if (idx_reg == used_reg) begin
                    state_next = ST_SUMM;
                end else begin
                    ram_raddr = idx_reg[AW-1:0];
                    state_next = ST_EMITW;
                end
            end
            ST_EMITW: begin
                // keep the read address so the row stays put through a stall
                ram_raddr = idx_reg[AW-1:0];
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_sum_next = 1'b0;
                    m_data_next = '0;
                    m_data_next[63:0]    = ram_rdata.key_lo;
                    m_data_next[127:64]  = ram_rdata.key_hi;
                    m_data_next[191:128] = ram_rdata.bytes;
                    m_data_next[223:192] = ram_rdata.count;
                    idx_next = idx_reg + 1'b1;
                    state_next = ST_EMITR;
                end
            end
            ST_SUMM: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_sum_next = 1'b1;
                    m_data_next = '0;
                    m_data_next[287:224] = unatt_reg;
                    m_data_next[351:288] = unrep_reg;
                    m_data_next[415:352] = rep_reg;
                    m_data_next[447:416] = dist_reg;
                    m_data_next[452:448] = 5'(used_reg);
                    used_next = '0; unatt_next = '0; unrep_next = '0;
                    rep_next = '0; dist_next = '0;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            used_reg <= '0; unatt_reg <= '0; unrep_reg <= '0; rep_reg <= '0;
            dist_reg <= '0; m_valid_reg <= 1'b0; m_sum_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            used_reg <= used_next; unatt_reg <= unatt_next; unrep_reg <= unrep_next;
            rep_reg <= rep_next; dist_reg <= dist_next;
            m_valid_reg <= m_valid_next; m_sum_reg <= m_sum_next;
        end
    end

    always_ff @(posedge aclk) begin
        klo_reg <= klo_next; khi_reg <= khi_next; bytes_reg <= bytes_next;
        idx_reg <= idx_next; pos_reg <= pos_next; hold_reg <= hold_next;
        m_data_reg <= m_data_next;
    end
endmodule

FILE: bench/tb.sv
// Testbench for keyed_byte_aggregation_ranker_unit: random and directed record streams,
// checked against an in-bench group-by/sort predictor. Depends on kbar_pkg and the RTL.
module tb;
    import kbar_pkg::*;

    localparam int NROWS = 16;

    typedef struct packed {
        logic         op;
        logic [335:0] data;
    } rec_item_t;

    typedef struct packed {
        logic         summ;
        logic [455:0] data;
        logic         lst;
    } report_t;

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [335:0] s_tdata = '0;
    logic [0:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [455:0] m_tdata;
    logic [0:0]   m_tuser;
    logic         m_tlast;
    logic         cfg_valid = 0;
    logic         cfg_ready;
    logic [7:0]   cfg_index = '0;
    logic [31:0]  cfg_data = '0;

    keyed_byte_aggregation_ranker_unit #(.ROWS(NROWS)) uut (.*);

    initial forever #5 aclk = ~aclk;

    // predictor state
    logic [63:0] pk_lo [NROWS];
    logic [63:0] pk_hi [NROWS];
    logic [63:0] pbytes [NROWS];
    logic [31:0] pcnt [NROWS];
    int          p_used;
    logic [63:0] p_unattr, p_unrep, p_rep;
    logic [31:0] p_distinct;
    logic [1:0]  cur_axis;
    logic [4:0]  cur_limit;

    rec_item_t   pending_recs[$];
    report_t     expected_reports[$];
    int          errors = 0;
    int          reports_seen = 0;
    int          finishes = 0;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        errors++;
    endtask

    // Apply one accepted item to the predictor; finish pushes the ranked report.
    task automatic predict_item(input rec_item_t it);
        logic [63:0] klo, khi, b;
        int cap, slot, p;
        logic [63:0] tl, th, bs;
        logic [31:0] tc;
        report_t r;
        if (it.op == OP_ADD) begin
            khi = 0;
            b = {16'd0, it.data[335:288]};
            case (cur_axis)
                AXIS_TYPE:   klo = it.data[63:0];
                AXIS_THREAD: klo = {32'd0, it.data[95:64]};
                AXIS_CELL:   klo = it.data[159:96];
                default: begin
                    klo = it.data[223:160];
                    khi = it.data[287:224];
                end
            endcase
            if (klo == 0 && khi == 0) begin
                p_unattr += b;
                return;
            end
            cap = (cur_limit < NROWS) ? cur_limit : NROWS;
            slot = p_used;
            for (int i = 0; i < p_used; i++)
                if (slot == p_used && pk_lo[i] == klo && pk_hi[i] == khi) slot = i;
            if (slot == p_used) begin
                p_distinct++;
                if (p_used >= cap) begin
                    p_unrep += b;
                    return;
                end
                pk_lo[slot] = klo; pk_hi[slot] = khi; pbytes[slot] = 0; pcnt[slot] = 0;
                p_used++;
            end
            pbytes[slot] += b;
            pcnt[slot] += 1;
            p_rep += b;
        end else begin
            // stable insertion sort, descending bytes
            for (int i = 1; i < p_used; i++) begin
                tl = pk_lo[i]; th = pk_hi[i]; bs = pbytes[i]; tc = pcnt[i];
                p = i;
                while (p > 0 && pbytes[p-1] < bs) begin
                    pk_lo[p] = pk_lo[p-1]; pk_hi[p] = pk_hi[p-1];
                    pbytes[p] = pbytes[p-1]; pcnt[p] = pcnt[p-1];
                    p--;
                end
                pk_lo[p] = tl; pk_hi[p] = th; pbytes[p] = bs; pcnt[p] = tc;
            end
            for (int i = 0; i < p_used; i++) begin
                r = '0;
                r.data[63:0] = pk_lo[i];
                r.data[127:64] = pk_hi[i];
                r.data[191:128] = pbytes[i];
                r.data[223:192] = pcnt[i];
                expected_reports.push_back(r);
            end
            r = '0;
            r.summ = 1; r.lst = 1;
            r.data[287:224] = p_unattr;
            r.data[351:288] = p_unrep;
            r.data[415:352] = p_rep;
            r.data[447:416] = p_distinct;
            r.data[452:448] = p_used[4:0];
            expected_reports.push_back(r);
            p_used = 0; p_unattr = 0; p_unrep = 0; p_rep = 0; p_distinct = 0;
        end
    endtask

    // driver: bursts with random gaps
    int gap_left = 0;
    int burst_left = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                predict_item('{op: s_tuser[0], data: s_tdata});
                if (s_tuser[0] == OP_FINISH) finishes++;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 0;
                end else if (pending_recs.size() > 0) begin
                    s_tvalid <= 1;
                    s_tuser <= pending_recs[0].op;
                    s_tdata <= pending_recs[0].data;
                    void'(pending_recs.pop_front());
                    if (burst_left > 0) burst_left--;
                    else begin
                        burst_left = $urandom_range(0, 12);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
                    end
                end else s_tvalid <= 0;
            end
        end
    end

    // monitor and receiver stall pattern
    int stall_phase = 0;
    always @(posedge aclk) begin
        report_t e;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                reports_seen++;
                if (expected_reports.size() == 0)
                    report_mismatch("unexpected report item");
                else begin
                    e = expected_reports.pop_front();
                    if (m_tuser[0] !== e.summ) report_mismatch("is_summary");
                    if (m_tlast !== e.lst) report_mismatch("last");
                    if (m_tdata[63:0] !== e.data[63:0]) report_mismatch("key_lower");
                    if (m_tdata[127:64] !== e.data[127:64]) report_mismatch("key_upper");
                    if (m_tdata[191:128] !== e.data[191:128]) report_mismatch("row_bytes");
                    if (m_tdata[223:192] !== e.data[223:192])
                        report_mismatch("row_allocations");
                    if (m_tdata[287:224] !== e.data[287:224])
                        report_mismatch("unattributed_total");
                    if (m_tdata[351:288] !== e.data[351:288])
                        report_mismatch("unreported_total");
                    if (m_tdata[415:352] !== e.data[415:352])
                        report_mismatch("reported_total");
                    if (m_tdata[447:416] !== e.data[447:416])
                        report_mismatch("distinct_count");
                    if (m_tdata[452:448] !== e.data[452:448])
                        report_mismatch("rows_reported");
                end
            end
            stall_phase = (stall_phase + 1) % 64;
            if (stall_phase < 24) m_tready <= 1;
            else m_tready <= ($urandom_range(0, 2) != 0);
        end
    end

    // key pool keeps collisions frequent on every axis
    logic [63:0] pool_a [8];
    function automatic rec_item_t make_add(input int mode);
        rec_item_t it;
        int k;
        it.op = OP_ADD;
        k = $urandom_range(0, 7);
        it.data[63:0] = (mode == 0) ? pool_a[k] : {$urandom, $urandom};
        k = $urandom_range(0, 7);
        it.data[95:64] = (mode == 0) ? pool_a[k][31:0] : $urandom;
        k = $urandom_range(0, 7);
        it.data[159:96] = (mode == 0) ? pool_a[k] : {$urandom, $urandom};
        k = $urandom_range(0, 7);
        it.data[223:160] = (mode == 0) ? pool_a[k] : {$urandom, $urandom};
        it.data[287:224] = (mode == 0) ? pool_a[(k + 3) % 8] : {$urandom, $urandom};
        it.data[335:288] = ($urandom_range(0, 9) == 0) ? 48'hFFFF_FFFF_FFFF :
                           48'({$urandom, $urandom});
        return it;
    endfunction

    function automatic rec_item_t make_finish();
        rec_item_t it;
        it.op = OP_FINISH;
        it.data = 336'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                         $urandom, $urandom, $urandom, $urandom, $urandom});
        return it;
    endfunction

    task automatic write_reg(input logic [7:0] idx, input logic [31:0] val);
        @(posedge aclk);
        cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == REG_AXIS) cur_axis = val[1:0];
        else if (idx == REG_LIMIT) cur_limit = val[4:0];
        cfg_valid <= 0;
    endtask

    task automatic drain();
        while (pending_recs.size() > 0 || s_tvalid || expected_reports.size() > 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    initial begin
        rec_item_t it;
        int nphase;
        p_used = 0; p_unattr = 0; p_unrep = 0; p_rep = 0; p_distinct = 0;
        cur_axis = 0; cur_limit = 16;
        pool_a[0] = 0; pool_a[1] = 64'hFFFF_FFFF_FFFF_FFFF; pool_a[2] = 1;
        for (int i = 3; i < 8; i++) pool_a[i] = {$urandom, $urandom};
        repeat (6) @(posedge aclk);
        aresetn <= 1;

        // directed: empty finish, zero key, extremes, overflow at small limit
        pending_recs.push_back(make_finish());
        it = '0; it.op = OP_ADD; it.data[335:288] = 48'hFFFF_FFFF_FFFF;
        pending_recs.push_back(it);
        it.data = '1; pending_recs.push_back(it); pending_recs.push_back(it);
        it.data = '0; it.data[0] = 1; it.data[335:288] = 48'd5; pending_recs.push_back(it);
        pending_recs.push_back(make_finish());
        drain();
        write_reg(REG_LIMIT, 0);
        it.data = '1; pending_recs.push_back(it);
        pending_recs.push_back(make_finish());
        drain();
        write_reg(REG_LIMIT, 2);
        for (int a = 0; a < 4; a++) begin
            write_reg(REG_AXIS, a);
            for (int i = 0; i < 4; i++) pending_recs.push_back(make_add(0));
            pending_recs.push_back(make_add(1));
            pending_recs.push_back(make_finish());
            drain();
        end
        // limit lowered below rows in use: new keys then count as unreported
        write_reg(REG_LIMIT, 16);
        for (int i = 0; i < 6; i++) pending_recs.push_back(make_add(1));
        drain();
        write_reg(REG_LIMIT, 1);
        for (int i = 0; i < 6; i++) pending_recs.push_back(make_add(0));
        pending_recs.push_back(make_finish());
        drain();
        write_reg(8'd7, 32'hFFFF_FFFF);

        // random phases across settings
        for (int ph = 0; ph < 12; ph++) begin
            write_reg(REG_AXIS, $urandom_range(0, 3));
            case (ph % 4)
                0: write_reg(REG_LIMIT, 31);
                1: write_reg(REG_LIMIT, 16);
                2: write_reg(REG_LIMIT, $urandom_range(0, 15));
                default: write_reg(REG_LIMIT, $urandom_range(17, 31));
            endcase
            nphase = $urandom_range(18, 30);
            for (int i = 0; i < nphase; i++) begin
                if ($urandom_range(0, 11) == 0) pending_recs.push_back(make_finish());
                else pending_recs.push_back(make_add($urandom_range(0, 4) == 0));
            end
            pending_recs.push_back(make_finish());
            drain();
        end
        $display("Covered %0d finish reports, %0d report items, all axes and limits 0..31.",
                 finishes, reports_seen);
        if (errors == 0) $display("Testbench completed without errors");
        else $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #20000000;
        $display("Timeout with %0d reports outstanding", expected_reports.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

FILE: sim.f
rtl/kbar_pkg.sv
rtl/kbar_ram.sv
rtl/keyed_byte_aggregation_ranker_unit.sv
bench/tb.sv
